/* src/crr_pkg.sv */
// shared types and constants for the cell range reference parser
// no dependencies; imported by every module of the block
package crr_pkg;

	localparam int VALUE_WIDTH_DEF = 24;
	localparam int COORD_W         = 24;
	localparam int CFG_W           = 24;
	localparam int CFG_IDX_W       = 2;
	localparam int CH_W            = 8;
	localparam int OUT_DATA_W      = 4 * COORD_W;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NOTATION   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROW    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_COLUMN = 2'd2;

	localparam logic [COORD_W-1:0] MAX_ROW_RST    = 24'd1048576;
	localparam logic [COORD_W-1:0] MAX_COLUMN_RST = 24'd16384;

	localparam int RADIX_ALPHA = 26;
	localparam int RADIX_DEC   = 10;

	localparam logic [CH_W-1:0] CH_COLON    = 8'h3A;
	localparam logic [CH_W-1:0] CH_DOLLAR   = 8'h24;
	localparam logic [CH_W-1:0] CH_R        = 8'h52;
	localparam logic [CH_W-1:0] CH_C        = 8'h43;
	localparam logic [CH_W-1:0] CH_UP_A     = 8'h41;
	localparam logic [CH_W-1:0] CH_UP_Z     = 8'h5A;
	localparam logic [CH_W-1:0] CH_LO_A     = 8'h61;
	localparam logic [CH_W-1:0] CH_LO_Z     = 8'h7A;
	localparam logic [CH_W-1:0] CH_ZERO     = 8'h30;
	localparam logic [CH_W-1:0] CH_NINE     = 8'h39;
	localparam logic [CH_W-1:0] CASE_OFFSET = 8'h20;

	typedef enum logic [3:0] {
		PH_CELL,
		PH_A1_DOLLAR1,
		PH_A1_LETTERS,
		PH_A1_DOLLAR2,
		PH_A1_DIGITS,
		PH_RC_ROW0,
		PH_RC_ROW,
		PH_RC_COL0,
		PH_RC_COL
	} crr_phase_t;

	typedef struct packed {
		crr_phase_t phase;
		logic       seen_colon;
		logic       failed;
	} crr_ctrl_t;

	// parse state at the end of a reference, handed to the finish stage
	typedef struct packed {
		crr_phase_t         phase;
		logic               failed;
		logic               seen_colon;
		logic [COORD_W-1:0] cell_row;
		logic [COORD_W-1:0] cell_col;
		logic [COORD_W-1:0] first_row;
		logic [COORD_W-1:0] first_col;
	} crr_snap_t;

endpackage

/* src/crr_step.sv */
// next-state logic of the reference parser for one character
// depends on crr_pkg
module crr_step #(
	parameter int VALUE_WIDTH = crr_pkg::VALUE_WIDTH_DEF
) (
	input  logic [crr_pkg::CH_W-1:0]    ch,
	input  logic                        has_char,
	input  logic                        notation,
	input  logic [crr_pkg::COORD_W-1:0] max_row,
	input  logic [crr_pkg::COORD_W-1:0] max_column,
	input  crr_pkg::crr_ctrl_t          ctrl,
	input  logic [VALUE_WIDTH:0]        accum,
	input  logic [crr_pkg::COORD_W-1:0] cell_row,
	input  logic [crr_pkg::COORD_W-1:0] cell_col,
	input  logic [crr_pkg::COORD_W-1:0] first_row_held,
	input  logic [crr_pkg::COORD_W-1:0] first_col_held,
	output crr_pkg::crr_ctrl_t          n_ctrl,
	output logic [VALUE_WIDTH:0]        n_accum,
	output logic [crr_pkg::COORD_W-1:0] n_cell_row,
	output logic [crr_pkg::COORD_W-1:0] n_cell_col,
	output logic [crr_pkg::COORD_W-1:0] n_first_row_held,
	output logic [crr_pkg::COORD_W-1:0] n_first_col_held
);
	import crr_pkg::*;

	localparam int AW = VALUE_WIDTH + 1;
	localparam int PW = AW + 5;
	localparam int EW = AW + COORD_W;

	logic             letter, digit, fail;
	logic [CH_W-1:0]  up, lsub, dsub;
	logic [4:0]       lval;
	logic [3:0]       dval;
	logic [AW-1:0]    cap, acc_base, acc26, acc10;
	logic [PW-1:0]    sum26, sum10;
	logic [EW-1:0]    acc_ext;
	logic             row_ok, col_ok;
	logic [COORD_W-1:0] row_val, col_val;

	assign letter = (ch >= CH_UP_A && ch <= CH_UP_Z) || (ch >= CH_LO_A && ch <= CH_LO_Z);
	assign digit  = ch >= CH_ZERO && ch <= CH_NINE;
	assign up     = (ch >= CH_LO_A && ch <= CH_LO_Z) ? ch - CASE_OFFSET : ch;
	assign lsub   = up - CH_UP_A + 8'd1;
	assign dsub   = ch - CH_ZERO;
	assign lval   = lsub[4:0];
	assign dval   = dsub[3:0];

	// running number saturates at 2^VALUE_WIDTH
	assign cap      = AW'(1) << VALUE_WIDTH;
	assign acc_base = (ctrl.phase == PH_CELL) ? '0 : accum;
	assign sum26    = PW'(acc_base) * PW'(RADIX_ALPHA) + PW'(lval);
	assign sum10    = PW'(acc_base) * PW'(RADIX_DEC) + PW'(dval);
	assign acc26    = (sum26 > PW'(cap)) ? cap : sum26[AW-1:0];
	assign acc10    = (sum10 > PW'(cap)) ? cap : sum10[AW-1:0];

	// number end checks against the limits
	assign acc_ext = EW'(accum);
	assign row_ok  = (accum != '0) && (acc_ext <= EW'(max_row));
	assign col_ok  = (accum != '0) && (acc_ext <= EW'(max_column));
	assign row_val = row_ok ? acc_ext[COORD_W-1:0] : '0;
	assign col_val = col_ok ? acc_ext[COORD_W-1:0] : '0;

	always_comb begin
		n_ctrl           = ctrl;
		n_accum          = accum;
		n_cell_row       = cell_row;
		n_cell_col       = cell_col;
		n_first_row_held = first_row_held;
		n_first_col_held = first_col_held;
		fail             = 1'b0;
		if (has_char && !ctrl.failed) begin
			unique case (ctrl.phase)
				PH_CELL: begin
					n_accum = '0;
					if (!notation) begin
						if (ch == CH_DOLLAR) begin
							n_ctrl.phase = PH_A1_DOLLAR1;
						end else if (letter) begin
							n_accum      = acc26;
							n_ctrl.phase = PH_A1_LETTERS;
						end else begin
							fail = 1'b1;
						end
					end else if (up == CH_R) begin
						n_ctrl.phase = PH_RC_ROW0;
					end else begin
						fail = 1'b1;
					end
				end
				PH_A1_DOLLAR1: begin
					if (letter) begin
						n_accum      = acc26;
						n_ctrl.phase = PH_A1_LETTERS;
					end else begin
						fail = 1'b1;
					end
				end
				PH_A1_LETTERS: begin
					if (letter) begin
						n_accum = acc26;
					end else if (ch == CH_DOLLAR || digit) begin
						// column ends; a digit starts the row from zero
						fail       = !col_ok;
						n_cell_col = col_val;
						if (digit) begin
							n_accum      = AW'(dval);
							n_ctrl.phase = PH_A1_DIGITS;
						end else begin
							n_accum      = '0;
							n_ctrl.phase = PH_A1_DOLLAR2;
						end
					end else begin
						fail = 1'b1;
					end
				end
				PH_A1_DOLLAR2, PH_RC_ROW0, PH_RC_COL0: begin
					if (digit) begin
						n_accum = acc10;
						case (ctrl.phase)
							PH_A1_DOLLAR2: n_ctrl.phase = PH_A1_DIGITS;
							PH_RC_ROW0:    n_ctrl.phase = PH_RC_ROW;
							default:       n_ctrl.phase = PH_RC_COL;
						endcase
					end else begin
						fail = 1'b1;
					end
				end
				PH_RC_ROW: begin
					if (digit) begin
						n_accum = acc10;
					end else if (up == CH_C) begin
						fail         = !row_ok;
						n_cell_row   = row_val;
						n_accum      = '0;
						n_ctrl.phase = PH_RC_COL0;
					end else begin
						fail = 1'b1;
					end
				end
				PH_A1_DIGITS, PH_RC_COL: begin
					if (digit) begin
						n_accum = acc10;
					end else if (ch == CH_COLON && !ctrl.seen_colon) begin
						n_accum = '0;
						if (ctrl.phase == PH_A1_DIGITS) begin
							fail             = !row_ok;
							n_cell_row       = row_val;
							n_first_row_held = row_val;
							n_first_col_held = cell_col;
						end else begin
							fail             = !col_ok;
							n_cell_col       = col_val;
							n_first_row_held = cell_row;
							n_first_col_held = col_val;
						end
						n_ctrl.seen_colon = 1'b1;
						n_ctrl.phase      = PH_CELL;
					end else begin
						fail = 1'b1;
					end
				end
				default: fail = 1'b1;
			endcase
			if (fail) begin
				n_ctrl.failed = 1'b1;
			end
		end
	end

endmodule

/* src/crr_finish.sv */
// end-of-reference check and result register of the parser
// depends on crr_pkg
module crr_finish #(
	parameter int VALUE_WIDTH = crr_pkg::VALUE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  crr_pkg::crr_snap_t             snap,
	input  logic [VALUE_WIDTH:0]           accum,
	input  logic [crr_pkg::COORD_W-1:0]    max_row,
	input  logic [crr_pkg::COORD_W-1:0]    max_column,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [crr_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                           m_tuser
);
	import crr_pkg::*;

	localparam int AW = VALUE_WIDTH + 1;
	localparam int EW = AW + COORD_W;

	logic [EW-1:0]      acc_ext;
	logic               row_ok, col_ok, end_ok, ok;
	logic [COORD_W-1:0] row_fin, col_fin, row_first, col_first;
	logic               out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic               out_ok_q;

	assign acc_ext = EW'(accum);
	assign row_ok  = (accum != '0) && (acc_ext <= EW'(max_row));
	assign col_ok  = (accum != '0) && (acc_ext <= EW'(max_column));

	// the number still open at the end closes the last cell
	assign row_fin = (snap.phase == PH_A1_DIGITS) ? acc_ext[COORD_W-1:0] : snap.cell_row;
	assign col_fin = (snap.phase == PH_RC_COL) ? acc_ext[COORD_W-1:0] : snap.cell_col;
	// a single cell is both ends of the range
	assign row_first = snap.seen_colon ? snap.first_row : row_fin;
	assign col_first = snap.seen_colon ? snap.first_col : col_fin;
	assign end_ok  = (snap.phase == PH_A1_DIGITS && row_ok) ||
	                 (snap.phase == PH_RC_COL && col_ok);
	assign ok      = !snap.failed && end_ok &&
	                 !(row_first > row_fin) && !(col_first > col_fin);

	assign in_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			out_ok_q   <= ok;
			out_data_q <= ok ? {col_fin, row_fin, col_first, row_first} : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_ok_q;

endmodule

/* src/cell_range_reference_parser_core.sv */
// Range reference parser, one character per transfer. Each accepted character
// is registered, then updates the parse state from that register; a character
// marked tlast closes the text and its state goes through one more register
// for the final limit and ordering checks before the result register. The
// block takes one character every cycle while results are taken. Characters
// without tlast give no result. notation, max_row and max_column are written
// through the cfg port; the user must do so only while the parser is idle, and
// the block does not enforce it. Depends on crr_pkg, crr_step, crr_finish.
module cell_range_reference_parser_core #(
	parameter int VALUE_WIDTH = crr_pkg::VALUE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [crr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [crr_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,  // ch
	input  logic                           s_tuser,  // has_char
	input  logic                           s_tlast,  // last
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// first_row, first_col, last_row, last_col, from the low bits up
	output logic [crr_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                           m_tuser   // valid_res
);
	import crr_pkg::*;

	logic               notation_q;
	logic [COORD_W-1:0] max_row_q, max_column_q;

	logic               valid_s1, has_char_s1, last_s1;
	logic [CH_W-1:0]    ch_s1;

	crr_ctrl_t          ctrl_q, n_ctrl;
	logic [VALUE_WIDTH:0] accum_q, n_accum;
	logic [COORD_W-1:0] cell_row_q, cell_col_q, first_row_held_q, first_col_held_q;
	logic [COORD_W-1:0] n_cell_row, n_cell_col, n_first_row_held, n_first_col_held;

	logic               valid_s2;
	crr_snap_t          snap_s2;
	logic [VALUE_WIDTH:0] accum_s2;

	logic               fin_ready, s2_free, s1_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			notation_q   <= 1'b0;
			max_row_q    <= MAX_ROW_RST;
			max_column_q <= MAX_COLUMN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NOTATION:   notation_q   <= cfg_data[0];
				CFG_MAX_ROW:    max_row_q    <= cfg_data;
				CFG_MAX_COLUMN: max_column_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// only a closing character needs room further down
	assign s2_free  = !valid_s2 || fin_ready;
	assign s1_move  = valid_s1 && (!last_s1 || s2_free);
	assign s_tready = !valid_s1 || s1_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1       <= s_tdata;
			has_char_s1 <= s_tuser;
			last_s1     <= s_tlast;
		end
	end

	crr_step #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_step (
		.ch               (ch_s1),
		.has_char         (has_char_s1),
		.notation         (notation_q),
		.max_row          (max_row_q),
		.max_column       (max_column_q),
		.ctrl             (ctrl_q),
		.accum            (accum_q),
		.cell_row         (cell_row_q),
		.cell_col         (cell_col_q),
		.first_row_held   (first_row_held_q),
		.first_col_held   (first_col_held_q),
		.n_ctrl           (n_ctrl),
		.n_accum          (n_accum),
		.n_cell_row       (n_cell_row),
		.n_cell_col       (n_cell_col),
		.n_first_row_held (n_first_row_held),
		.n_first_col_held (n_first_col_held)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q           <= '{phase: PH_CELL, seen_colon: 1'b0, failed: 1'b0};
			accum_q          <= '0;
			cell_row_q       <= '0;
			cell_col_q       <= '0;
			first_row_held_q <= '0;
			first_col_held_q <= '0;
		end else if (s1_move) begin
			if (last_s1) begin
				ctrl_q           <= '{phase: PH_CELL, seen_colon: 1'b0, failed: 1'b0};
				accum_q          <= '0;
				cell_row_q       <= '0;
				cell_col_q       <= '0;
				first_row_held_q <= '0;
				first_col_held_q <= '0;
			end else begin
				ctrl_q           <= n_ctrl;
				accum_q          <= n_accum;
				cell_row_q       <= n_cell_row;
				cell_col_q       <= n_cell_col;
				first_row_held_q <= n_first_row_held;
				first_col_held_q <= n_first_col_held;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_move && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (fin_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && last_s1) begin
			snap_s2.phase      <= n_ctrl.phase;
			snap_s2.failed     <= n_ctrl.failed;
			snap_s2.seen_colon <= n_ctrl.seen_colon;
			snap_s2.cell_row   <= n_cell_row;
			snap_s2.cell_col   <= n_cell_col;
			snap_s2.first_row  <= n_first_row_held;
			snap_s2.first_col  <= n_first_col_held;
			accum_s2           <= n_accum;
		end
	end

	crr_finish #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_finish (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (valid_s2),
		.in_ready   (fin_ready),
		.snap       (snap_s2),
		.accum      (accum_s2),
		.max_row    (max_row_q),
		.max_column (max_column_q),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule
